// ===== hw/rtl/x86_prefix_opcode_census_defines.svh =====
// Assertion macros shared by the x86 prefix and opcode census RTL.
`ifndef X86_PREFIX_OPCODE_CENSUS_DEFINES_SVH
`define X86_PREFIX_OPCODE_CENSUS_DEFINES_SVH

// Same-cycle implication, sampled on clk, off while rst_n is low
`define POC_ASSERT_IMPL(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, sampled on clk, off while rst_n is low
`define POC_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

// ===== hw/rtl/poc_pkg.sv =====
// Types, codes and prefix decode shared by the census modules.
package poc_pkg;

  // Request kinds carried on in_tuser
  typedef enum logic [1:0] {
    CMD_BYTE  = 2'd0,
    CMD_EMPTY = 2'd1,
    CMD_READ  = 2'd2,
    CMD_NONE  = 2'd3
  } cmd_t;

  // Per-sample decode phase
  typedef enum logic [1:0] {
    PH_IDLE   = 2'd0,
    PH_PREFIX = 2'd1,
    PH_ESC    = 2'd2,
    PH_DONE   = 2'd3
  } phase_t;

  // Sample outcome codes
  typedef enum logic [1:0] {
    OUT_PLAIN     = 2'd0,
    OUT_ESCAPE    = 2'd1,
    OUT_PREFIXES  = 2'd2,
    OUT_ESC_TRUNC = 2'd3
  } outcome_t;

  // Result kinds carried on out_tuser
  localparam logic RK_READ    = 1'b0;
  localparam logic RK_SUMMARY = 1'b1;

  // Source of a read result
  typedef enum logic [1:0] {
    SRC_ZERO = 2'd0,
    SRC_CTR  = 2'd1,
    SRC_OPH  = 2'd2,
    SRC_ESCH = 2'd3
  } src_t;

  // Prefix limit per sample
  localparam logic [3:0] MAX_PREFIXES = 4'd14;

  // Scalar counter indexes
  localparam int NUM_CTRS   = 11;
  localparam int C_EMPTY    = 0;
  localparam int C_SAMPLE   = 1;
  localparam int C_OVERFLOW = 2;
  localparam int C_PREFIXED = 3;
  localparam int C_SEGMENT  = 4;
  localparam int C_TRUNC    = 9;
  localparam int C_ESCAPE   = 10;

  // Histogram geometry
  localparam int HIST_DEPTH = 256;
  localparam int HIST_AW    = 8;

  // Result queue depth
  localparam int QDEPTH = 3;

  // Byte codes
  localparam logic [7:0] B_ESCAPE = 8'h0F;
  localparam logic [7:0] B_SEG_ES = 8'h26;
  localparam logic [7:0] B_SEG_CS = 8'h2E;
  localparam logic [7:0] B_SEG_SS = 8'h36;
  localparam logic [7:0] B_SEG_DS = 8'h3E;
  localparam logic [7:0] B_SEG_FS = 8'h64;
  localparam logic [7:0] B_SEG_GS = 8'h65;
  localparam logic [7:0] B_OPSIZE = 8'h66;
  localparam logic [7:0] B_ADSIZE = 8'h67;
  localparam logic [7:0] B_REPNE  = 8'hF2;
  localparam logic [7:0] B_REP    = 8'hF3;
  localparam logic [7:0] B_LOCK   = 8'hF0;

  // Per-item events from the sample decoder
  typedef struct packed {
    logic [NUM_CTRS-1:0] bumps;
    logic                op_en;
    logic                esc_en;
    logic                summ;
    logic [7:0]          opcode;
    logic [7:0]          second;
    logic [3:0]          tally;
    logic [4:0]          kinds;
    outcome_t            outcome;
    logic                ovf;
  } ev_t;

  // One result item
  typedef struct packed {
    logic       result_kind;
    logic [31:0] read_value;
    logic [7:0] opcode;
    logic [7:0] second_opcode;
    logic [3:0] prefixes_seen;
    logic [4:0] prefix_kinds;
    outcome_t   outcome;
    logic       overflowed;
  } item_t;

  // Prefix kind bits: segment, operand size, address size, repeat, lock
  function automatic logic [4:0] pfx_kinds(input logic [7:0] b);
    logic [4:0] k;
    k    = '0;
    k[0] = (b == B_SEG_ES) || (b == B_SEG_CS) || (b == B_SEG_SS) ||
           (b == B_SEG_DS) || (b == B_SEG_FS) || (b == B_SEG_GS);
    k[1] = (b == B_OPSIZE);
    k[2] = (b == B_ADSIZE);
    k[3] = (b == B_REPNE) || (b == B_REP);
    k[4] = (b == B_LOCK);
    return k;
  endfunction

endpackage

// ===== hw/rtl/poc_parse.sv =====
// Per-sample prefix and opcode decoder with its small sample state.
module poc_parse (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             byte_v,
  input  logic             empty_v,
  input  logic [7:0]       b,
  input  logic             last,
  output poc_pkg::ev_t     ev
);

  poc_pkg::phase_t phase_r, phase_nxt;
  logic [3:0] tally_r, tally_nxt;
  logic [4:0] kinds_r, kinds_nxt;
  logic       ovf_r, ovf_nxt;
  logic [7:0] op_r, op_nxt;
  logic [7:0] sec_r, sec_nxt;

  poc_pkg::phase_t ph_eff, ph1;
  logic [4:0] bk;
  logic       is_pfx, take_pfx, take_op, take_sec, fin, end_pfx;
  logic [3:0] tally1;
  logic [4:0] kinds1;
  logic       ovf1;
  logic [7:0] op1, sec1;

  // Decode this byte against the current sample
  assign ph_eff   = (phase_r == poc_pkg::PH_IDLE) ? poc_pkg::PH_PREFIX : phase_r;
  assign bk       = poc_pkg::pfx_kinds(b);
  assign is_pfx   = |bk;
  assign take_pfx = byte_v && (ph_eff == poc_pkg::PH_PREFIX) && is_pfx &&
                    (tally_r < poc_pkg::MAX_PREFIXES);
  assign take_op  = byte_v && (ph_eff == poc_pkg::PH_PREFIX) && !take_pfx;
  assign take_sec = byte_v && (ph_eff == poc_pkg::PH_ESC);
  assign fin      = byte_v && last;

  assign tally1 = take_pfx ? tally_r + 4'd1 : tally_r;
  assign kinds1 = take_pfx ? (kinds_r | bk) : kinds_r;
  assign ovf1   = ovf_r | (take_op && is_pfx);
  assign op1    = take_op ? b : op_r;
  assign sec1   = take_sec ? b : sec_r;
  assign ph1    = take_op  ? ((b == poc_pkg::B_ESCAPE) ? poc_pkg::PH_ESC : poc_pkg::PH_DONE) :
                  take_sec ? poc_pkg::PH_DONE : ph_eff;

  // Prefix run ends on the opcode or on a sample that stops inside the prefixes
  assign end_pfx = (take_op || (fin && (ph1 == poc_pkg::PH_PREFIX))) && (tally1 != 4'd0);

  // Next sample state
  always_comb begin
    phase_nxt = phase_r;
    tally_nxt = tally_r;
    kinds_nxt = kinds_r;
    ovf_nxt   = ovf_r;
    op_nxt    = op_r;
    sec_nxt   = sec_r;
    if (empty_v || fin) begin
      phase_nxt = poc_pkg::PH_IDLE;
      tally_nxt = '0;
      kinds_nxt = '0;
      ovf_nxt   = 1'b0;
      op_nxt    = '0;
      sec_nxt   = '0;
    end else if (byte_v) begin
      phase_nxt = ph1;
      tally_nxt = tally1;
      kinds_nxt = kinds1;
      ovf_nxt   = ovf1;
      op_nxt    = op1;
      sec_nxt   = sec1;
    end
  end

  // Events and summary for this item
  always_comb begin
    ev        = '0;
    ev.bumps[poc_pkg::C_EMPTY]    = empty_v;
    ev.bumps[poc_pkg::C_SAMPLE]   = byte_v && (phase_r == poc_pkg::PH_IDLE);
    ev.bumps[poc_pkg::C_OVERFLOW] = take_op && is_pfx;
    ev.bumps[poc_pkg::C_PREFIXED] = end_pfx;
    for (int i = 0; i < 5; i++) begin
      ev.bumps[poc_pkg::C_SEGMENT + i] = end_pfx && kinds1[i];
    end
    ev.bumps[poc_pkg::C_TRUNC]  = fin && ((ph1 == poc_pkg::PH_PREFIX) ||
                                          (ph1 == poc_pkg::PH_ESC));
    ev.bumps[poc_pkg::C_ESCAPE] = take_op && (b == poc_pkg::B_ESCAPE);
    ev.op_en  = take_op;
    ev.esc_en = take_sec;
    ev.summ   = fin;
    ev.tally  = tally1;
    ev.kinds  = kinds1;
    ev.ovf    = ovf1;
    ev.opcode = op1;
    unique case (ph1)
      poc_pkg::PH_PREFIX: begin
        ev.outcome = poc_pkg::OUT_PREFIXES;
        ev.opcode  = '0;
      end
      poc_pkg::PH_ESC: ev.outcome = poc_pkg::OUT_ESC_TRUNC;
      default: begin
        ev.outcome = (op1 == poc_pkg::B_ESCAPE) ? poc_pkg::OUT_ESCAPE : poc_pkg::OUT_PLAIN;
      end
    endcase
    ev.second = (ev.outcome == poc_pkg::OUT_ESCAPE) ? sec1 : 8'd0;
  end

  // Sample state registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= poc_pkg::PH_IDLE;
      tally_r <= '0;
      kinds_r <= '0;
      ovf_r   <= 1'b0;
      op_r    <= '0;
      sec_r   <= '0;
    end else begin
      phase_r <= phase_nxt;
      tally_r <= tally_nxt;
      kinds_r <= kinds_nxt;
      ovf_r   <= ovf_nxt;
      op_r    <= op_nxt;
      sec_r   <= sec_nxt;
    end
  end

endmodule

// ===== hw/rtl/poc_hist.sv =====
// 256-entry histogram memory with clearing pass, read-modify-write and forwarding.
`include "x86_prefix_opcode_census_defines.svh"

module poc_hist #(
  parameter int CW = 32
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        rd_en,
  input  logic                        bump,
  input  logic [poc_pkg::HIST_AW-1:0] rd_addr,
  output logic [CW-1:0]               rd_value,
  output logic                        clr_done
);

  logic [CW-1:0]               mem_r [poc_pkg::HIST_DEPTH];
  logic [CW-1:0]               rd_data_r;
  logic [CW-1:0]               fwd_data_r;
  logic                        fwd_r;
  logic                        s1_bump_r;
  logic [poc_pkg::HIST_AW-1:0] s1_addr_r;
  logic [poc_pkg::HIST_AW:0]   clr_cnt_r;

  logic                        wr_en;
  logic [poc_pkg::HIST_AW-1:0] wr_addr;
  logic [CW-1:0]               wr_data;

  // Entry value seen by the access in flight, newest write first
  assign rd_value = fwd_r ? fwd_data_r : rd_data_r;
  assign clr_done = clr_cnt_r[poc_pkg::HIST_AW];

  // Single write port: clearing sweep, then increments
  always_comb begin
    wr_en   = !clr_done || s1_bump_r;
    wr_addr = clr_done ? s1_addr_r : clr_cnt_r[poc_pkg::HIST_AW-1:0];
    wr_data = clr_done ? rd_value + CW'(1) : '0;
  end

  // Memory array
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_r <= mem_r[rd_addr];
    end
  end

  // Access tracking and forwarding of the write that lands with a new read
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_bump_r <= 1'b0;
      fwd_r     <= 1'b0;
      clr_cnt_r <= '0;
    end else begin
      s1_bump_r <= rd_en && bump;
      fwd_r     <= rd_en && s1_bump_r && (rd_addr == s1_addr_r);
      if (!clr_done) begin
        clr_cnt_r <= clr_cnt_r + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    fwd_data_r <= wr_data;
    if (rd_en) begin
      s1_addr_r <= rd_addr;
    end
  end

  `POC_ASSERT_NEXT(a_clr_stays_done, clr_done, clr_done, "histogram clear restarted")
  `POC_ASSERT_IMPL(a_no_bump_in_clear, !clr_done, !s1_bump_r, "increment during clear")

endmodule

// ===== hw/rtl/poc_ctrs.sv =====
// Bank of scalar event counters with a registered read port.
module poc_ctrs #(
  parameter int CW = 32
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic [poc_pkg::NUM_CTRS-1:0] bumps,
  input  logic                         rd_en,
  input  logic [3:0]                   rd_idx,
  output logic [CW-1:0]                rd_value
);

  logic [CW-1:0] cnt_r [poc_pkg::NUM_CTRS];
  logic [CW-1:0] rd_r;

  assign rd_value = rd_r;

  // Advance every flagged counter, wrapping
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < poc_pkg::NUM_CTRS; i++) begin
        cnt_r[i] <= '0;
      end
    end else begin
      for (int i = 0; i < poc_pkg::NUM_CTRS; i++) begin
        if (bumps[i]) begin
          cnt_r[i] <= cnt_r[i] + CW'(1);
        end
      end
    end
  end

  // Capture the addressed counter; the caller only asks for valid indexes
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_r <= cnt_r[rd_idx];
    end
  end

endmodule

// ===== hw/rtl/poc_out_q.sv =====
// Small result queue that parts the pipeline from the output handshake.
module poc_out_q (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          push,
  input  poc_pkg::item_t push_item,
  input  logic          pop_ready,
  output logic          head_valid,
  output poc_pkg::item_t head_item,
  output logic [1:0]    cnt
);

  poc_pkg::item_t ent_r [poc_pkg::QDEPTH];
  logic [1:0] head_r, head_nxt;
  logic [1:0] tail_r, tail_nxt;
  logic [1:0] cnt_r, cnt_nxt;
  logic       pop;

  assign head_valid = (cnt_r != 2'd0);
  assign head_item  = ent_r[head_r];
  assign cnt        = cnt_r;
  assign pop        = head_valid && pop_ready;

  // Advance pointers with wrap at the queue depth
  always_comb begin
    head_nxt = head_r;
    tail_nxt = tail_r;
    if (pop) begin
      head_nxt = (head_r == 2'(poc_pkg::QDEPTH - 1)) ? 2'd0 : head_r + 2'd1;
    end
    if (push) begin
      tail_nxt = (tail_r == 2'(poc_pkg::QDEPTH - 1)) ? 2'd0 : tail_r + 2'd1;
    end
    cnt_nxt = cnt_r + 2'(push) - 2'(pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      head_r <= '0;
      tail_r <= '0;
      cnt_r  <= '0;
    end else begin
      head_r <= head_nxt;
      tail_r <= tail_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      ent_r[tail_r] <= push_item;
    end
  end

endmodule

// ===== hw/rtl/x86_prefix_opcode_census.sv =====
// Top level of the x86 legacy prefix and opcode census.
//
//  channel | dir | handshake        | payload
//  in_     | in  | tvalid / tready  | tdata: data_byte, read_address; tuser: cmd; tlast
//  out_    | out | tvalid / tready  | tdata: read value and sample summary; tuser: kind
//
// One request per cycle while in_tready is high; each result is staged with its histogram
// memory or counter read, then passes through the result queue.
// Reset clears both 256-entry histograms in a sweep; in_tready stays low until it ends.
// in_tready drops when the three-entry result queue plus the stage in flight is full.
// A histogram increment hitting the entry read in the next cycle is forwarded.
`include "x86_prefix_opcode_census_defines.svh"

module x86_prefix_opcode_census #(
  parameter int COUNTER_WIDTH = 32
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [23:0] in_tdata,   // data_byte[7:0], read_address[17:8], zero[23:18]
  input  logic [1:0]  in_tuser,   // cmd[1:0]
  input  logic        in_tlast,
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [63:0] out_tdata,  // read_value[31:0], opcode[39:32], second_opcode[47:40],
                                  // prefixes_seen[51:48], prefix_kinds[56:52],
                                  // outcome[58:57], overflowed[59], zero[63:60]
  output logic        out_tuser   // result_kind
);

  localparam int CW = COUNTER_WIDTH;

  logic           accept, is_byte, is_read;
  logic [7:0]     dbyte;
  logic [9:0]     raddr;
  logic           r_ctr, r_oph, r_esch;
  poc_pkg::ev_t   ev;

  logic           oph_en, esch_en, oph_done, esch_done, clr_done;
  logic [CW-1:0]  oph_val, esch_val, ctr_val;

  logic           s1_valid_r;
  poc_pkg::item_t s1_item_r, s1_item_nxt, push_item, head_item;
  poc_pkg::src_t  s1_src_r, s1_src_nxt;
  logic [1:0]     q_cnt;

  // Decode the request
  assign dbyte   = in_tdata[7:0];
  assign raddr   = in_tdata[17:8];
  assign accept  = in_tvalid && in_tready;
  assign is_byte = (in_tuser == poc_pkg::CMD_BYTE);
  assign is_read = (in_tuser == poc_pkg::CMD_READ);
  assign r_ctr   = (raddr < 10'(poc_pkg::NUM_CTRS));
  assign r_oph   = (raddr[9:8] == 2'd1);
  assign r_esch  = (raddr[9:8] == 2'd2);

  poc_parse u_parse (
    .clk     (clk),
    .rst_n   (rst_n),
    .byte_v  (accept && is_byte),
    .empty_v (accept && (in_tuser == poc_pkg::CMD_EMPTY)),
    .b       (dbyte),
    .last    (in_tlast),
    .ev      (ev)
  );

  poc_ctrs #(.CW(CW)) u_ctrs (
    .clk      (clk),
    .rst_n    (rst_n),
    .bumps    (ev.bumps),
    .rd_en    (accept && is_read && r_ctr),
    .rd_idx   (raddr[3:0]),
    .rd_value (ctr_val)
  );

  // Histogram accesses: increments from bytes, lookups from reads
  assign oph_en  = accept && ((is_byte && ev.op_en) || (is_read && r_oph));
  assign esch_en = accept && ((is_byte && ev.esc_en) || (is_read && r_esch));

  poc_hist #(.CW(CW)) u_oph (
    .clk      (clk),
    .rst_n    (rst_n),
    .rd_en    (oph_en),
    .bump     (is_byte),
    .rd_addr  (is_read ? raddr[7:0] : dbyte),
    .rd_value (oph_val),
    .clr_done (oph_done)
  );

  poc_hist #(.CW(CW)) u_esch (
    .clk      (clk),
    .rst_n    (rst_n),
    .rd_en    (esch_en),
    .bump     (is_byte),
    .rd_addr  (is_read ? raddr[7:0] : dbyte),
    .rd_value (esch_val),
    .clr_done (esch_done)
  );

  assign clr_done  = oph_done && esch_done;
  assign in_tready = clr_done &&
                     ((3'(q_cnt) + 3'(s1_valid_r)) < 3'(poc_pkg::QDEPTH));

  // Stage the result of this request
  always_comb begin
    s1_item_nxt               = '0;
    s1_item_nxt.result_kind   = is_read ? poc_pkg::RK_READ : poc_pkg::RK_SUMMARY;
    s1_src_nxt                = poc_pkg::SRC_ZERO;
    if (is_read) begin
      if (r_ctr) begin
        s1_src_nxt = poc_pkg::SRC_CTR;
      end else if (r_oph) begin
        s1_src_nxt = poc_pkg::SRC_OPH;
      end else if (r_esch) begin
        s1_src_nxt = poc_pkg::SRC_ESCH;
      end
    end else begin
      s1_item_nxt.opcode        = ev.opcode;
      s1_item_nxt.second_opcode = ev.second;
      s1_item_nxt.prefixes_seen = ev.tally;
      s1_item_nxt.prefix_kinds  = ev.kinds;
      s1_item_nxt.outcome       = ev.outcome;
      s1_item_nxt.overflowed    = ev.ovf;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else begin
      s1_valid_r <= accept && (is_read || (is_byte && ev.summ));
    end
  end

  always_ff @(posedge clk) begin
    s1_item_r <= s1_item_nxt;
    s1_src_r  <= s1_src_nxt;
  end

  // Fill in read data once the memory or counter read has returned
  always_comb begin
    push_item = s1_item_r;
    case (s1_src_r)
      poc_pkg::SRC_CTR:  push_item.read_value = 32'(ctr_val);
      poc_pkg::SRC_OPH:  push_item.read_value = 32'(oph_val);
      poc_pkg::SRC_ESCH: push_item.read_value = 32'(esch_val);
      default:           push_item.read_value = '0;
    endcase
  end

  poc_out_q u_q (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (s1_valid_r),
    .push_item  (push_item),
    .pop_ready  (out_tready),
    .head_valid (out_tvalid),
    .head_item  (head_item),
    .cnt        (q_cnt)
  );

  // Pack the result onto the bus
  assign out_tuser = head_item.result_kind;
  assign out_tdata = {4'd0, head_item.overflowed, head_item.outcome,
                      head_item.prefix_kinds, head_item.prefixes_seen,
                      head_item.second_opcode, head_item.opcode, head_item.read_value};

  `POC_ASSERT_IMPL(a_q_no_overrun, q_cnt == 2'(poc_pkg::QDEPTH), !s1_valid_r, "result queue overrun")
  `POC_ASSERT_IMPL(a_quiet_in_clear, !clr_done, !out_tvalid && !s1_valid_r, "result during clear")

endmodule
